// ----- sv/mamu_pkg.sv -----
// Package for the modular add / multiply unit.
// Holds the data width, derived widths, stage counts and opcode codes.
// No dependencies.
`default_nettype none
package mamu_pkg;
  localparam int unsigned W    = 64;
  localparam int unsigned H    = W / 2;
  localparam int unsigned NRED = 2 * W;

  typedef logic [W-1:0]   word_t;
  typedef logic [2*W-1:0] dword_t;
  typedef logic [H-1:0]   half_t;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_MUL = 1'b1
  } op_t;
endpackage
`default_nettype wire

// ----- sv/modular_add_multiply_unit_top.sv -----
// Top level of the modular add / multiply unit.
// Uses mamu_pkg for widths and opcode codes.
//
// Usage: an item is transferred on the in_ channel when in_valid and in_ready
// are both high. It carries an opcode (add or multiply), two unsigned operands
// and a modulus. One result is transferred on the out_ channel per item, in
// order. A zero modulus gives the plain sum or product wrapped to the data
// width; any other modulus gives the full sum or full double-width product
// reduced by that modulus.
// The pipeline is an input register, a stage of four half-width partial
// products (or the operand sum for add), a stage that sums them into the full
// product, then one restoring reduction stage per bit of the double-width
// value. Throughput is one item per cycle while the receiver does not stall.
// The pipeline advances as a whole while the last stage is empty or its
// result is being transferred; when the receiver stalls, every stage holds
// and in_ready drops, so nothing is lost or repeated.
// Reset clears all stage valid bits; no result is pending after reset.
`default_nettype none
module modular_add_multiply_unit_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_opcode,
  input  wire mamu_pkg::word_t     in_operand_a,
  input  wire mamu_pkg::word_t     in_operand_b,
  input  wire mamu_pkg::word_t     in_modulus,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mamu_pkg::word_t          out_result
);
  localparam int unsigned W    = mamu_pkg::W;
  localparam int unsigned H    = mamu_pkg::H;
  localparam int unsigned NRED = mamu_pkg::NRED;

  logic en;

  logic            s0_vld_r;
  logic            s0_op_r;
  mamu_pkg::word_t s0_a_r, s0_b_r, s0_m_r;

  logic            s1_vld_r;
  mamu_pkg::word_t s1_ll_r, s1_lh_r, s1_hl_r, s1_hh_r, s1_m_r;
  logic [W:0]      s1_sum_r;
  logic            s1_op_r;

  logic             red_vld_r [NRED+1];
  mamu_pkg::dword_t red_x_r   [NRED+1];
  mamu_pkg::word_t  red_rem_r [NRED+1];
  mamu_pkg::word_t  red_m_r   [NRED+1];

  mamu_pkg::dword_t s2_x_nxt;

  assign en       = !red_vld_r[NRED] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
    if (en) begin
      s0_op_r <= in_opcode;
      s0_a_r  <= in_operand_a;
      s0_b_r  <= in_operand_b;
      s0_m_r  <= in_modulus;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
    if (en) begin
      s1_ll_r  <= W'(s0_a_r[H-1:0]) * W'(s0_b_r[H-1:0]);
      s1_lh_r  <= W'(s0_a_r[H-1:0]) * W'(s0_b_r[W-1:H]);
      s1_hl_r  <= W'(s0_a_r[W-1:H]) * W'(s0_b_r[H-1:0]);
      s1_hh_r  <= W'(s0_a_r[W-1:H]) * W'(s0_b_r[W-1:H]);
      s1_sum_r <= {1'b0, s0_a_r} + {1'b0, s0_b_r};
      s1_op_r  <= s0_op_r;
      s1_m_r   <= s0_m_r;
    end
  end

  always_comb begin
    case (mamu_pkg::op_t'(s1_op_r))
      mamu_pkg::OP_MUL: begin
        s2_x_nxt = {s1_hh_r, s1_ll_r}
                 + ((2*W)'(s1_lh_r) << H)
                 + ((2*W)'(s1_hl_r) << H);
      end
      default: begin
        s2_x_nxt = (2*W)'(s1_sum_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_vld_r[0] <= 1'b0;
    end else if (en) begin
      red_vld_r[0] <= s1_vld_r;
    end
    if (en) begin
      red_x_r[0]   <= s2_x_nxt;
      red_rem_r[0] <= '0;
      red_m_r[0]   <= s1_m_r;
    end
  end

  for (genvar k = 0; k < NRED; k++) begin : g_red
    logic [W:0]      t;
    logic [W:0]      d;
    mamu_pkg::word_t rem_nxt;

    assign t       = {red_rem_r[k], red_x_r[k][NRED-1-k]};
    assign d       = t - {1'b0, red_m_r[k]};
    assign rem_nxt = (t >= {1'b0, red_m_r[k]}) ? d[W-1:0] : t[W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        red_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        red_vld_r[k+1] <= red_vld_r[k];
      end
      if (en) begin
        red_x_r[k+1]   <= red_x_r[k];
        red_rem_r[k+1] <= rem_nxt;
        red_m_r[k+1]   <= red_m_r[k];
      end
    end
  end

  assign out_valid  = red_vld_r[NRED];
  assign out_result = (red_m_r[NRED] == '0) ? red_x_r[NRED][W-1:0] : red_rem_r[NRED];

  a_in_to_s0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s0_vld_r)
    else $error("accepted input did not reach the first stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en) |=> ($stable(red_vld_r[NRED]) && $stable(s0_vld_r)))
    else $error("pipeline moved during a stall");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (red_vld_r[NRED] && red_m_r[NRED] != '0) |-> (red_rem_r[NRED] < red_m_r[NRED]))
    else $error("reduced result not below modulus");

  a_ready_en: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while output stalled");
endmodule
`default_nettype wire
